>>> src/owbm_pkg.sv
// ---------------------------------------------------------------------------
// owbm_pkg: shared types and constants for the 1-Wire bus master
// Action codes, register map, phase codes, the item struct and
// the Dallas CRC-8 byte update.
// ---------------------------------------------------------------------------
package owbm_pkg;

  // Field widths
  localparam int unsigned ActionW = 3;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned UsW     = 11;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned NumRegs = 8;

  // Action codes on the request channel
  localparam logic [ActionW-1:0] ACT_TICK  = 3'd0;
  localparam logic [ActionW-1:0] ACT_RESET = 3'd1;
  localparam logic [ActionW-1:0] ACT_WRITE = 3'd2;
  localparam logic [ActionW-1:0] ACT_READ  = 3'd3;
  localparam logic [ActionW-1:0] ACT_CLEAR = 3'd4;

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_RESET_LOW   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_PRES_SAMPLE = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SHORT_LOW   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_W0_LOW      = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_W1_HIGH     = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_W0_HIGH     = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_RD_SAMPLE   = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_RD_TAIL     = 3'd7;

  // Register reset values
  localparam logic [UsW-1:0] REG_RESET_VALS [NumRegs] = '{
    11'd480, 11'd40, 11'd3, 11'd60, 11'd60, 11'd10, 11'd12, 11'd55
  };

  // Released time ahead of the reset pulse
  localparam logic [UsW-1:0] RESET_IDLE_US = 11'd1000;

  // CRC-8 constants (x^8+x^5+x^4+1, reflected)
  localparam logic [ByteW-1:0] CRC_MIX = 8'h18;
  localparam logic [ByteW-1:0] CRC_TOP = 8'h80;

  // Classified operation
  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_RESET = 3'd1,
    OP_WRITE = 3'd2,
    OP_READ  = 3'd3,
    OP_CLEAR = 3'd4
  } op_e;

  // Bus phase, one-hot
  typedef enum logic [9:0] {
    PH_IDLE      = 10'b00_0000_0001,
    PH_RST_IDLE  = 10'b00_0000_0010,
    PH_RST_LOW   = 10'b00_0000_0100,
    PH_PRES_WAIT = 10'b00_0000_1000,
    PH_WAIT_HIGH = 10'b00_0001_0000,
    PH_WLOW      = 10'b00_0010_0000,
    PH_WHIGH     = 10'b00_0100_0000,
    PH_RLOW      = 10'b00_1000_0000,
    PH_RSAMP     = 10'b01_0000_0000,
    PH_RTAIL     = 10'b10_0000_0000
  } phase_e;

  // Request after classification
  typedef struct packed {
    op_e             op;
    logic [ByteW-1:0] wdata;
    logic             line;
  } item_t;

  // Dallas CRC-8 over one byte, LSB first
  function automatic logic [ByteW-1:0] crc8_byte(input logic [ByteW-1:0] crc,
                                                 input logic [ByteW-1:0] data);
    logic [ByteW-1:0] c;
    logic [ByteW-1:0] b;
    c = crc;
    b = data;
    for (int k = 0; k < ByteW; k++) begin
      if ((c[0] ^ b[0]) == 1'b1) begin
        c = c ^ CRC_MIX;
        c = (c >> 1) | CRC_TOP;
      end else begin
        c = c >> 1;
      end
      b = b >> 1;
    end
    return c;
  endfunction

endpackage

>>> src/owbm_if.sv
// ---------------------------------------------------------------------------
// owbm_if: channel interfaces of the 1-Wire bus master
// Request, result and register-write channels, each valid/ready.
// ---------------------------------------------------------------------------
interface owbm_in_if;
  logic                        valid;
  logic                        ready;
  logic [owbm_pkg::ActionW-1:0] action;
  logic [owbm_pkg::ByteW-1:0]   write_data;
  logic                        line_level;

  modport source (output valid, action, write_data, line_level, input ready);
  modport sink   (input valid, action, write_data, line_level, output ready);
endinterface

interface owbm_out_if;
  logic                      valid;
  logic                      ready;
  logic                      drive_low;
  logic                      busy_res;
  logic                      done_res;
  logic                      presence;
  logic [owbm_pkg::ByteW-1:0] read_byte;
  logic [owbm_pkg::ByteW-1:0] crc_value;
  logic                      rejected;

  modport source (output valid, drive_low, busy_res, done_res, presence, read_byte,
                  crc_value, rejected, input ready);
  modport sink   (input valid, drive_low, busy_res, done_res, presence, read_byte,
                  crc_value, rejected, output ready);
endinterface

interface owbm_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [owbm_pkg::CfgIdxW-1:0] index;
  logic [owbm_pkg::UsW-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> src/owbm_front.sv
// ---------------------------------------------------------------------------
// owbm_front: request intake
// Classifies each request and holds it in a two-entry queue for the back end.
// ---------------------------------------------------------------------------
module owbm_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  owbm_in_if.sink             in_i,
  output logic                q_valid_o,
  output owbm_pkg::item_t     q_item_o,
  input  logic                q_pop_i
);

  owbm_pkg::item_t mem_q [2];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      count_q, count_d;
  owbm_pkg::item_t item_in;
  logic            push;
  logic            pop;

  // Classify the action; unused codes are plain ticks
  always_comb begin
    item_in.wdata = in_i.write_data;
    item_in.line  = in_i.line_level;
    case (in_i.action)
      owbm_pkg::ACT_RESET: item_in.op = owbm_pkg::OP_RESET;
      owbm_pkg::ACT_WRITE: item_in.op = owbm_pkg::OP_WRITE;
      owbm_pkg::ACT_READ:  item_in.op = owbm_pkg::OP_READ;
      owbm_pkg::ACT_CLEAR: item_in.op = owbm_pkg::OP_CLEAR;
      default:             item_in.op = owbm_pkg::OP_TICK;
    endcase
  end

  assign in_i.ready = (count_q != 2'd2);
  assign push       = in_i.valid && in_i.ready;
  assign pop        = q_pop_i && (count_q != 2'd0);
  assign q_valid_o  = (count_q != 2'd0);
  assign q_item_o   = mem_q[rd_ptr_q];

  // Queue pointers
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

  // Queue never overfills nor underflows
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3) else $error("queue count out of range");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd2 && !pop) |=> count_q == 2'd2) else $error("full queue lost entry");
  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> count_q == $past(count_q) - 2'd1) else $error("pop count slip");

endmodule

>>> src/owbm_back.sv
// ---------------------------------------------------------------------------
// owbm_back: bus sequencer
// Runs one microsecond step per request: command start, phase timing,
// bit shifting, presence and CRC; results leave through an output register.
// ---------------------------------------------------------------------------
module owbm_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  owbm_cfg_if.sink        cfg_i,
  input  logic            q_valid_i,
  input  owbm_pkg::item_t q_item_i,
  output logic            q_pop_o,
  owbm_out_if.source      out_o
);

  localparam int unsigned UsW   = owbm_pkg::UsW;
  localparam int unsigned ByteW = owbm_pkg::ByteW;

  logic [UsW-1:0]   regs_q [owbm_pkg::NumRegs];

  owbm_pkg::phase_e phase_q, phase_d, ph_a;
  logic [UsW-1:0]   cnt_q, cnt_d, cnt_a;
  logic [ByteW-1:0] sh_q, sh_d, sh_a;
  logic [2:0]       bc_q, bc_d, bc_a;
  logic [ByteW-1:0] crc_q, crc_d, crc_a;
  logic             pres_q, pres_d;
  logic [ByteW-1:0] last_q, last_d;
  logic             rej, done, drive;
  logic             take;
  logic             is_cmd;

  // Output register
  logic             ovalid_q;
  logic             odrive_q, obusy_q, odone_q, orej_q;

  assign take    = q_valid_i && (!ovalid_q || out_o.ready);
  assign q_pop_o = take;

  // Register writes
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q <= owbm_pkg::REG_RESET_VALS;
    end else if (cfg_i.valid) begin
      regs_q[cfg_i.index] <= cfg_i.data;
    end
  end

  assign is_cmd = (q_item_i.op == owbm_pkg::OP_RESET) ||
                  (q_item_i.op == owbm_pkg::OP_WRITE) ||
                  (q_item_i.op == owbm_pkg::OP_READ);

  // One step: command start, then the tick
  always_comb begin
    ph_a  = phase_q;
    cnt_a = cnt_q;
    sh_a  = sh_q;
    bc_a  = bc_q;
    crc_a = crc_q;
    rej   = 1'b0;

    if (q_item_i.op == owbm_pkg::OP_CLEAR) begin
      crc_a = '0;
    end
    if (is_cmd) begin
      if (phase_q != owbm_pkg::PH_IDLE) begin
        rej = 1'b1;
      end else begin
        bc_a = '0;
        case (q_item_i.op)
          owbm_pkg::OP_RESET: begin
            ph_a  = owbm_pkg::PH_RST_IDLE;
            cnt_a = owbm_pkg::RESET_IDLE_US;
          end
          owbm_pkg::OP_WRITE: begin
            sh_a  = q_item_i.wdata;
            ph_a  = owbm_pkg::PH_WLOW;
            cnt_a = q_item_i.wdata[0] ? regs_q[owbm_pkg::REG_SHORT_LOW]
                                      : regs_q[owbm_pkg::REG_W0_LOW];
          end
          default: begin
            sh_a  = '0;
            ph_a  = owbm_pkg::PH_RLOW;
            cnt_a = regs_q[owbm_pkg::REG_SHORT_LOW];
          end
        endcase
      end
    end

    phase_d = ph_a;
    cnt_d   = cnt_a;
    sh_d    = sh_a;
    bc_d    = bc_a;
    crc_d   = crc_a;
    pres_d  = pres_q;
    last_d  = last_q;
    done    = 1'b0;
    drive   = 1'b0;

    if (ph_a != owbm_pkg::PH_IDLE) begin
      drive = (ph_a == owbm_pkg::PH_RST_LOW) || (ph_a == owbm_pkg::PH_WLOW) ||
              (ph_a == owbm_pkg::PH_RLOW);
      if (ph_a == owbm_pkg::PH_WAIT_HIGH) begin
        if (q_item_i.line) begin
          phase_d = owbm_pkg::PH_IDLE;
          cnt_d   = '0;
          done    = 1'b1;
        end
      end else if (cnt_a > 11'd1) begin
        cnt_d = cnt_a - 11'd1;
      end else begin
        // Phase ends on this tick
        case (ph_a)
          owbm_pkg::PH_RST_IDLE: begin
            phase_d = owbm_pkg::PH_RST_LOW;
            cnt_d   = regs_q[owbm_pkg::REG_RESET_LOW];
          end
          owbm_pkg::PH_RST_LOW: begin
            phase_d = owbm_pkg::PH_PRES_WAIT;
            cnt_d   = regs_q[owbm_pkg::REG_PRES_SAMPLE];
          end
          owbm_pkg::PH_PRES_WAIT: begin
            if (!q_item_i.line) begin
              pres_d  = 1'b1;
              phase_d = owbm_pkg::PH_WAIT_HIGH;
              cnt_d   = '0;
            end else begin
              pres_d  = 1'b0;
              phase_d = owbm_pkg::PH_IDLE;
              cnt_d   = '0;
              done    = 1'b1;
            end
          end
          owbm_pkg::PH_WLOW: begin
            phase_d = owbm_pkg::PH_WHIGH;
            cnt_d   = sh_a[0] ? regs_q[owbm_pkg::REG_W1_HIGH]
                              : regs_q[owbm_pkg::REG_W0_HIGH];
          end
          owbm_pkg::PH_WHIGH: begin
            sh_d = sh_a >> 1;
            if (bc_a == 3'd7) begin
              phase_d = owbm_pkg::PH_IDLE;
              cnt_d   = '0;
              done    = 1'b1;
            end else begin
              bc_d    = bc_a + 3'd1;
              phase_d = owbm_pkg::PH_WLOW;
              cnt_d   = sh_a[1] ? regs_q[owbm_pkg::REG_SHORT_LOW]
                                : regs_q[owbm_pkg::REG_W0_LOW];
            end
          end
          owbm_pkg::PH_RLOW: begin
            phase_d = owbm_pkg::PH_RSAMP;
            cnt_d   = regs_q[owbm_pkg::REG_RD_SAMPLE];
          end
          owbm_pkg::PH_RSAMP: begin
            sh_d    = {q_item_i.line, sh_a[ByteW-1:1]};
            phase_d = owbm_pkg::PH_RTAIL;
            cnt_d   = regs_q[owbm_pkg::REG_RD_TAIL];
          end
          owbm_pkg::PH_RTAIL: begin
            if (bc_a == 3'd7) begin
              last_d  = sh_a;
              crc_d   = owbm_pkg::crc8_byte(crc_a, sh_a);
              phase_d = owbm_pkg::PH_IDLE;
              cnt_d   = '0;
              done    = 1'b1;
            end else begin
              bc_d    = bc_a + 3'd1;
              phase_d = owbm_pkg::PH_RLOW;
              cnt_d   = regs_q[owbm_pkg::REG_SHORT_LOW];
            end
          end
          default: begin
            phase_d = owbm_pkg::PH_IDLE;
            cnt_d   = '0;
            done    = 1'b1;
          end
        endcase
      end
    end
  end

  // Sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= owbm_pkg::PH_IDLE;
      cnt_q   <= '0;
      sh_q    <= '0;
      bc_q    <= '0;
      crc_q   <= '0;
      pres_q  <= 1'b0;
      last_q  <= '0;
    end else if (take) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      sh_q    <= sh_d;
      bc_q    <= bc_d;
      crc_q   <= crc_d;
      pres_q  <= pres_d;
      last_q  <= last_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (take) begin
      ovalid_q <= 1'b1;
    end else if (out_o.ready) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      odrive_q <= drive;
      obusy_q  <= (phase_d != owbm_pkg::PH_IDLE);
      odone_q  <= done;
      orej_q   <= rej;
    end
  end

  assign out_o.valid     = ovalid_q;
  assign out_o.drive_low = odrive_q;
  assign out_o.busy_res  = obusy_q;
  assign out_o.done_res  = odone_q;
  assign out_o.rejected  = orej_q;
  assign out_o.presence  = pres_q;
  assign out_o.read_byte = last_q;
  assign out_o.crc_value = crc_q;

  // Consistency of the sequencer
  a_idle_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == owbm_pkg::PH_IDLE) |-> (cnt_q == '0)) else $error("idle with live counter");
  a_phase_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(phase_q)) else $error("phase not one-hot");
  a_busy_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q |-> !(obusy_q && odone_q)) else $error("busy and done together");
  a_drive_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && odrive_q) |-> obusy_q) else $error("bus driven while not busy");
  a_rej_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && orej_q) |-> (obusy_q || odone_q)) else $error("reject while idle");

endmodule

>>> src/one_wire_bus_master.sv
// ---------------------------------------------------------------------------
// one_wire_bus_master: 1-Wire master stepped one microsecond per request
// Front end classifies and queues requests; back end sequences the bus.
// ---------------------------------------------------------------------------
// Each request on in_i is one microsecond tick carrying the sampled bus level
// and optionally a command (reset/presence, write byte, read byte, clear CRC);
// each produces exactly one result on out_o with the drive level for that
// tick and the status. The block sustains one request per clock while out_o
// accepts its results: the sequencer in the back end does a full step per
// request, and the result is registered when its request is taken from the
// queue and offered in the cycle after. A two-entry queue between the front
// and back ends and a result register let either side stall without blocking
// the other. Register writes on cfg_i are always accepted and must only occur
// while the block is idle.
module one_wire_bus_master (
  input  logic       clk_i,
  input  logic       rst_ni,
  owbm_in_if.sink    in_i,
  owbm_out_if.source out_o,
  owbm_cfg_if.sink   cfg_i
);

  logic            q_valid;
  owbm_pkg::item_t q_item;
  logic            q_pop;

  owbm_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_pop_i   (q_pop)
  );

  owbm_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_i),
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .q_pop_o   (q_pop),
    .out_o     (out_o)
  );

endmodule
